FILE: design/rfb_pkg.sv
package rfb_pkg;

    // Input item kinds.
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FRAME = 2'd1;
    localparam logic [1:0] ST_IN_FRAME = 2'd2;

    // Byte positions inside one burst of results.
    localparam logic [2:0] POS_ADDR  = 3'd0;
    localparam logic [2:0] POS_TYPE  = 3'd1;
    localparam logic [2:0] POS_LEN   = 3'd2;
    localparam logic [2:0] POS_CK_HI = 3'd3;
    localparam logic [2:0] POS_CK_LO = 3'd4;

    localparam logic [15:0] LOW_MASK = 16'h00FF;

    // Command queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // One classified item. Payload and error items start at position POS_LEN,
    // with their byte in b2; headers start at POS_ADDR.
    typedef struct packed {
        logic [1:0]  status;
        logic        is_hdr;
        logic        has_cksum;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [15:0] cksum;
    } cmd_t;

endpackage

FILE: design/rfb_in_if.sv
interface rfb_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] dest_address;
    logic [7:0] message_type;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;

    modport source (
        output valid, func, dest_address, message_type, frame_length, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, func, dest_address, message_type, frame_length, payload_byte,
        output ready
    );
endinterface

FILE: design/rfb_out_if.sv
interface rfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       end_of_frame;
    logic [1:0] status;
    logic       last;

    modport source (
        output valid, tx_byte, end_of_frame, status, last,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, end_of_frame, status, last,
        output ready
    );
endinterface

FILE: design/response_frame_builder.sv
// Channel  Role   Per transfer
// in_ch    sink   func, dest_address, message_type, frame_length, payload_byte
// out_ch   source tx_byte, end_of_frame, status, last
//
// The output gives one result per cycle while out_ch is ready. A payload item
// inside a frame or an error item gives one result; a start item gives three
// results, or five with a zero length, and the payload item that closes a
// frame gives three. The byte sequencer in the back end sets this; a four-deep
// command queue lets the front keep taking items during header and checksum
// bursts. Reset clears the frame state, the queue and the output valid flag.
// Input and output stall independently; a held result keeps its value.
module response_frame_builder
    import rfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rfb_in_if.sink    in_ch,
    rfb_out_if.source out_ch
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    cmd_t head;
    logic empty;

    rfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    rfb_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    rfb_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

FILE: design/rfb_front.sv
module rfb_front
    import rfb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    rfb_in_if.sink   in_ch,
    input  logic     full,
    output logic     push,
    output cmd_t     push_cmd
);

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [7:0]  remaining_reg;
    logic [7:0]  remaining_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic        accept;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;
    assign push        = accept;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        remaining_next  = remaining_reg;
        sum_next        = sum_reg;
        push_cmd        = '0;
        push_cmd.status = ST_OK;
        if (in_ch.func == FUNC_START)
        begin
            if (frame_open_reg)
            begin
                push_cmd.status = ST_IN_FRAME;
            end
            else
            begin
                sum_next = {8'd0, in_ch.dest_address} + {8'd0, in_ch.message_type}
                         + {8'd0, in_ch.frame_length};
                remaining_next     = in_ch.frame_length;
                frame_open_next    = (in_ch.frame_length != 8'd0);
                push_cmd.is_hdr    = 1'b1;
                push_cmd.has_cksum = (in_ch.frame_length == 8'd0);
                push_cmd.b0        = in_ch.dest_address;
                push_cmd.b1        = in_ch.message_type;
                push_cmd.b2        = in_ch.frame_length;
                push_cmd.cksum     = sum_next;
            end
        end
        else
        begin
            if (!frame_open_reg)
            begin
                push_cmd.status = ST_NO_FRAME;
            end
            else
            begin
                sum_next           = sum_reg + {8'd0, in_ch.payload_byte};
                remaining_next     = remaining_reg - 8'd1;
                frame_open_next    = (remaining_next != 8'd0);
                push_cmd.has_cksum = (remaining_next == 8'd0);
                push_cmd.b2        = in_ch.payload_byte;
                push_cmd.cksum     = sum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            remaining_reg  <= 8'd0;
            sum_reg        <= 16'd0;
        end
        else if (accept)
        begin
            frame_open_reg <= frame_open_next;
            remaining_reg  <= remaining_next;
            sum_reg        <= sum_next;
        end
    end

endmodule

FILE: design/rfb_fifo.sv
module rfb_fifo
    import rfb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam logic [FIFO_AW:0] DEPTH_COUNT = FIFO_DEPTH[FIFO_AW:0];

    cmd_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign full  = (count_reg == DEPTH_COUNT);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    assign count_next = count_reg + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_COUNT)
        else $error("command queue count out of range");

endmodule

FILE: design/rfb_back.sv
module rfb_back
    import rfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  logic      empty,
    output logic      pop,
    rfb_out_if.source out_ch
);

    logic [2:0] step_reg;
    logic [2:0] pos;
    logic [2:0] last_pos;
    logic       load;
    logic [7:0] sel_byte;

    logic       out_valid_reg;
    logic [7:0] tx_byte_reg;
    logic       eof_reg;
    logic [1:0] status_reg;
    logic       last_reg;

    assign pos      = (head.is_hdr ? POS_ADDR : POS_LEN) + step_reg;
    assign last_pos = head.has_cksum ? POS_CK_LO : POS_LEN;
    // The output register is free when empty or when its result is taken now.
    assign load     = !empty && (!out_valid_reg || out_ch.ready);
    assign pop      = load && (pos == last_pos);

    always_comb
    begin
        case (pos)
            POS_ADDR:  sel_byte = head.b0;
            POS_TYPE:  sel_byte = head.b1;
            POS_LEN:   sel_byte = head.b2;
            POS_CK_HI: sel_byte = head.cksum[15:8];
            POS_CK_LO: sel_byte = 8'(head.cksum & LOW_MASK);
            default:   sel_byte = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg <= pop ? 3'd0 : step_reg + 3'd1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tx_byte_reg <= sel_byte;
            eof_reg     <= (pos == POS_CK_LO);
            status_reg  <= head.status;
            last_reg    <= (pos == last_pos);
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.tx_byte      = tx_byte_reg;
    assign out_ch.end_of_frame = eof_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.last         = last_reg;

    a_eof_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.end_of_frame |-> out_ch.last && out_ch.status == ST_OK)
        else $error("end of frame without last or with error status");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != ST_OK |-> out_ch.last && out_ch.tx_byte == 8'd0)
        else $error("error result is not a single zero byte");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pos <= last_pos)
        else $error("burst position ran past its last result");

endmodule

FILE: tb/response_frame_builder_test.sv
module response_frame_builder_test;
    import rfb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int IDLE_PERCENT   = 35;

    typedef struct packed {
        logic       func;
        logic [7:0] dest_address;
        logic [7:0] message_type;
        logic [7:0] frame_length;
        logic [7:0] payload_byte;
    } frame_req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       end_of_frame;
        logic [1:0] status;
        logic       last;
    } tx_beat_t;

    logic clk;
    logic rst_n;

    rfb_in_if  in_ch ();
    rfb_out_if out_ch ();

    response_frame_builder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    frame_req_t  req_backlog[$];
    tx_beat_t    tx_expected[$];
    frame_req_t  next_req;
    frame_req_t  taken_req;
    tx_beat_t    seen_beat;
    tx_beat_t    want_beat;
    logic        in_fire;
    int unsigned cycle_count;
    int unsigned stall_cycles;
    int unsigned fail_count;

    // Frame state as the block should hold it.
    logic        frame_live;
    logic [7:0]  bytes_left;
    logic [15:0] frame_sum;

    // Both sides run without idling through a window in the middle of the run.
    wire calm = (cycle_count >= 150) && (cycle_count < 450);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function void expect_byte(logic [7:0] b, logic eof, logic [1:0] st, logic lst);
        tx_beat_t beat;
        beat.tx_byte      = b;
        beat.end_of_frame = eof;
        beat.status       = st;
        beat.last         = lst;
        tx_expected.push_back(beat);
    endfunction

    function void expect_checksum();
        expect_byte(frame_sum[15:8], 1'b0, ST_OK, 1'b0);
        expect_byte(frame_sum[7:0], 1'b1, ST_OK, 1'b1);
        frame_live = 1'b0;
        bytes_left = 8'd0;
    endfunction

    function void predict_frame_bytes(frame_req_t r);
        if (r.func == FUNC_START)
        begin
            if (frame_live)
            begin
                expect_byte(8'd0, 1'b0, ST_IN_FRAME, 1'b1);
            end
            else
            begin
                frame_sum = {8'd0, r.dest_address} + {8'd0, r.message_type}
                    + {8'd0, r.frame_length};
                bytes_left = r.frame_length;
                expect_byte(r.dest_address, 1'b0, ST_OK, 1'b0);
                expect_byte(r.message_type, 1'b0, ST_OK, 1'b0);
                if (r.frame_length == 8'd0)
                begin
                    expect_byte(r.frame_length, 1'b0, ST_OK, 1'b0);
                    expect_checksum();
                end
                else
                begin
                    expect_byte(r.frame_length, 1'b0, ST_OK, 1'b1);
                    frame_live = 1'b1;
                end
            end
        end
        else if (!frame_live)
        begin
            expect_byte(8'd0, 1'b0, ST_NO_FRAME, 1'b1);
        end
        else
        begin
            frame_sum  = frame_sum + {8'd0, r.payload_byte};
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0)
            begin
                expect_byte(r.payload_byte, 1'b0, ST_OK, 1'b0);
                expect_checksum();
            end
            else
            begin
                expect_byte(r.payload_byte, 1'b0, ST_OK, 1'b1);
            end
        end
    endfunction

    function void check_tx(tx_beat_t got);
        if (tx_expected.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected transfer: tx_byte=%02h eof=%0b status=%0d last=%0b",
                         got.tx_byte, got.end_of_frame, got.status, got.last);
        end
        else
        begin
            want_beat = tx_expected.pop_front();
            if (got !== want_beat)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: expected tx_byte=%02h eof=%0b status=%0d last=%0b,",
                             want_beat.tx_byte, want_beat.end_of_frame, want_beat.status,
                             want_beat.last,
                             " got tx_byte=%02h eof=%0b status=%0d last=%0b",
                             got.tx_byte, got.end_of_frame, got.status, got.last);
            end
        end
    endfunction

    // Fields that the item kind does not use still carry random values.
    task queue_start(logic [7:0] addr, logic [7:0] mtype, logic [7:0] len);
        frame_req_t r;
        r.func         = FUNC_START;
        r.dest_address = addr;
        r.message_type = mtype;
        r.frame_length = len;
        r.payload_byte = 8'($urandom_range(255));
        req_backlog.push_back(r);
    endtask

    task queue_payload(logic [7:0] b);
        frame_req_t r;
        r.func         = FUNC_PAYLOAD;
        r.dest_address = 8'($urandom_range(255));
        r.message_type = 8'($urandom_range(255));
        r.frame_length = 8'($urandom_range(255));
        r.payload_byte = b;
        req_backlog.push_back(r);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_fire)
            begin
                if (req_backlog.size() != 0
                    && (calm || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    next_req = req_backlog.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.func         <= next_req.func;
                    in_ch.dest_address <= next_req.dest_address;
                    in_ch.message_type <= next_req.message_type;
                    in_ch.frame_length <= next_req.frame_length;
                    in_ch.payload_byte <= next_req.payload_byte;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            cycle_count++;
            in_fire <= in_ch.valid && in_ch.ready;
            // Predict before checking in case a result leaves in the same cycle.
            if (in_ch.valid && in_ch.ready)
            begin
                taken_req.func         = in_ch.func;
                taken_req.dest_address = in_ch.dest_address;
                taken_req.message_type = in_ch.message_type;
                taken_req.frame_length = in_ch.frame_length;
                taken_req.payload_byte = in_ch.payload_byte;
                predict_frame_bytes(taken_req);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                seen_beat.tx_byte      = out_ch.tx_byte;
                seen_beat.end_of_frame = out_ch.end_of_frame;
                seen_beat.status       = out_ch.status;
                seen_beat.last         = out_ch.last;
                check_tx(seen_beat);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", stall_cycles);
                $display("response_frame_builder verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned base;
        int unsigned len;
        in_ch.valid        = 1'b0;
        in_ch.func         = FUNC_START;
        in_ch.dest_address = 8'd0;
        in_ch.message_type = 8'd0;
        in_ch.frame_length = 8'd0;
        in_ch.payload_byte = 8'd0;
        out_ch.ready       = 1'b0;
        in_fire            = 1'b0;
        cycle_count        = 0;
        stall_cycles       = 0;
        fail_count         = 0;
        frame_live         = 1'b0;
        bytes_left         = 8'd0;
        frame_sum          = 16'd0;
        rst_n              = 1'b0;

        // Directed items: stray payload, zero-length frames at both header
        // extremes, a start inside an open frame, and frames of one and more bytes.
        queue_payload(8'h00);
        queue_start(8'hFF, 8'hFF, 8'h00);
        queue_start(8'h00, 8'h00, 8'h00);
        queue_start(8'hA5, 8'h5A, 8'h02);
        queue_start(8'h11, 8'h22, 8'h33);
        queue_payload(8'hFF);
        queue_payload(8'h00);
        queue_payload(8'hFF);
        queue_start(8'h00, 8'h00, 8'h01);
        queue_payload(8'h80);
        queue_start(8'h80, 8'h01, 8'h03);
        queue_payload(8'h01);
        queue_start(8'hFF, 8'hFF, 8'hFF);
        queue_payload(8'h7F);
        queue_payload(8'hFE);

        // The longest frame, all ones, makes the checksum wrap past 16 bits.
        queue_start(8'hFF, 8'hFF, 8'hFF);
        repeat (255) queue_payload(8'hFF);

        // Mostly well-formed short frames, with stray payloads between frames
        // and stray starts inside them.
        base = req_backlog.size();
        while (req_backlog.size() - base < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 8)
            begin
                queue_payload(8'($urandom_range(255)));
            end
            else
            begin
                if ($urandom_range(99) < 80)
                    len = $urandom_range(0, 6);
                else
                    len = $urandom_range(7, 24);
                queue_start(8'($urandom_range(255)), 8'($urandom_range(255)), 8'(len));
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(99) < 5)
                        queue_start(8'($urandom_range(255)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)));
                    queue_payload(8'($urandom_range(255)));
                end
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do @(posedge clk); while (req_backlog.size() != 0 || in_ch.valid);
        do @(posedge clk); while (tx_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && tx_expected.size() == 0)
            $display("response_frame_builder verification clean");
        else
            $display("response_frame_builder verification failed");
        $finish;
    end

endmodule
